[sv/obcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obcc_pkg: shared types and constants of the oriented box corner collision unit
// Holds the fixed-point format, the controller states and commands, and the
// command and status structures exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package obcc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int NUM_MAT    = 12;
    localparam int NUM_LIM    = 6;
    localparam int WORD_LIM   = 12;
    localparam int NUM_WORDS  = 18;

    localparam int IN_DATA_W  = 264;
    localparam int OUT_DATA_W = 8;

    // Multiplier operands: A is the wide operand, B is shifted out bit by bit.
    localparam int A_W        = 67;
    localparam int B_W        = 33;
    localparam int MC_W       = A_W + B_W;
    localparam int ACC_W      = 104;
    localparam int MUL_STEPS  = B_W;
    localparam int MCNT_W     = $clog2(MUL_STEPS);
    localparam int SQRT_STEPS = 32;
    localparam int SCNT_W     = $clog2(SQRT_STEPS);
    localparam int DIV_STEPS  = 32 + FRAC_BITS;
    localparam int DCNT_W     = $clog2(DIV_STEPS);

    localparam int CAM_HALF   = 1 << (FRAC_BITS - 3);
    localparam int CAM_DROP   = (46 * (1 << FRAC_BITS) + 5) / 10;

    typedef enum logic [4:0] {
        S_IDLE, S_N_ABS, S_N_SHIFT, S_N_SQ_GO, S_N_SQ_RUN, S_N_SQRT_GO, S_N_SQRT_RUN,
        S_N_DIV_GO, S_N_DIV_RUN, S_N_DIV_ST, S_P_GO, S_P_RUN, S_P_ST, S_F_LD, S_F_GO,
        S_F_RUN, S_F_ST, S_C_CAM, S_D_GO, S_D_RUN, S_D_EVAL, S_D_HIT, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_QLATCH, OP_ABS, OP_SHIFT, OP_MUL, OP_SQRT, OP_DIV,
        OP_DIV_ST, OP_PT_ST, OP_LD_P, OP_N_ST, OP_CAM, OP_EVAL, OP_HIT
    } t_op;

    typedef enum logic [1:0] {M_SQ, M_CORNER, M_CROSS, M_DOT} t_msel;

    typedef struct packed {
        t_op        op;
        t_msel      msel;
        logic       acc_clr;
        logic       vec;
        logic [2:0] k;
        logic [1:0] i;
        logic [2:0] f;
        logic [1:0] t;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic need_shift;
        logic mul_busy;
        logic mul_done;
        logic sqrt_done;
        logic div_done;
        logic is_query;
        logic hit;
    } t_status;

    typedef struct packed {
        logic [4:0]         word_index;
        logic signed [31:0] word_value;
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic signed [31:0] fwd_x;
        logic signed [31:0] fwd_z;
        logic signed [31:0] right_x;
        logic signed [31:0] right_z;
    } t_item;

endpackage

[sv/obcc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obcc_ctrl: sequencing controller
// Walks a query through normalisation, object corners, face planes and the
// camera corner tests, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module obcc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_func,
    input  logic              i_out_free,
    input  obcc_pkg::t_status i_st,
    output logic              o_in_ready,
    output logic              o_emit,
    output obcc_pkg::t_cmd    o_cmd
);

    obcc_pkg::t_state r_state, n_state;
    logic       r_vec, n_vec;
    logic [2:0] r_k, n_k;
    logic [1:0] r_i, n_i;
    logic [2:0] r_f, n_f;
    logic [1:0] r_t, n_t;
    logic       w_accept;

    assign w_accept = i_in_valid && (r_state == obcc_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= obcc_pkg::S_IDLE;
            r_vec   <= 1'b0;
            r_k     <= '0;
            r_i     <= '0;
            r_f     <= '0;
            r_t     <= '0;
        end else begin
            r_state <= n_state;
            r_vec   <= n_vec;
            r_k     <= n_k;
            r_i     <= n_i;
            r_f     <= n_f;
            r_t     <= n_t;
        end
    end

    always_comb begin
        n_state = r_state;
        n_vec   = r_vec;
        n_k     = r_k;
        n_i     = r_i;
        n_f     = r_f;
        n_t     = r_t;
        unique case (r_state)
            obcc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_vec = 1'b0;
                    n_k   = '0;
                    n_i   = '0;
                    n_f   = '0;
                    n_t   = '0;
                    n_state = i_func ? obcc_pkg::S_N_ABS : obcc_pkg::S_DONE;
                end
            end
            obcc_pkg::S_N_ABS: n_state = obcc_pkg::S_N_SHIFT;
            obcc_pkg::S_N_SHIFT: begin
                if (i_st.zero) begin
                    n_state = obcc_pkg::S_DONE;
                end else if (!i_st.need_shift) begin
                    n_t     = '0;
                    n_state = obcc_pkg::S_N_SQ_GO;
                end
            end
            obcc_pkg::S_N_SQ_GO: n_state = obcc_pkg::S_N_SQ_RUN;
            obcc_pkg::S_N_SQ_RUN: begin
                if (i_st.mul_done) begin
                    if (r_t == 2'd0) begin
                        n_t     = 2'd1;
                        n_state = obcc_pkg::S_N_SQ_GO;
                    end else begin
                        n_t     = '0;
                        n_state = obcc_pkg::S_N_SQRT_GO;
                    end
                end
            end
            obcc_pkg::S_N_SQRT_GO: n_state = obcc_pkg::S_N_SQRT_RUN;
            obcc_pkg::S_N_SQRT_RUN: begin
                if (i_st.sqrt_done) n_state = obcc_pkg::S_N_DIV_GO;
            end
            obcc_pkg::S_N_DIV_GO: n_state = obcc_pkg::S_N_DIV_RUN;
            obcc_pkg::S_N_DIV_RUN: begin
                if (i_st.div_done) n_state = obcc_pkg::S_N_DIV_ST;
            end
            obcc_pkg::S_N_DIV_ST: begin
                if (r_t == 2'd0) begin
                    n_t     = 2'd1;
                    n_state = obcc_pkg::S_N_DIV_GO;
                end else begin
                    n_t = '0;
                    if (!r_vec) begin
                        n_vec   = 1'b1;
                        n_state = obcc_pkg::S_N_ABS;
                    end else begin
                        n_k     = '0;
                        n_i     = '0;
                        n_state = obcc_pkg::S_P_GO;
                    end
                end
            end
            obcc_pkg::S_P_GO: n_state = obcc_pkg::S_P_RUN;
            obcc_pkg::S_P_RUN: begin
                if (i_st.mul_done) begin
                    if (r_t < 2'd2) begin
                        n_t     = r_t + 2'd1;
                        n_state = obcc_pkg::S_P_GO;
                    end else begin
                        n_state = obcc_pkg::S_P_ST;
                    end
                end
            end
            obcc_pkg::S_P_ST: begin
                n_t = '0;
                if (r_i < 2'd2) begin
                    n_i     = r_i + 2'd1;
                    n_state = obcc_pkg::S_P_GO;
                end else begin
                    n_i = '0;
                    if (r_k < 3'd7) begin
                        n_k     = r_k + 3'd1;
                        n_state = obcc_pkg::S_P_GO;
                    end else begin
                        n_k     = '0;
                        n_f     = '0;
                        n_state = obcc_pkg::S_F_LD;
                    end
                end
            end
            obcc_pkg::S_F_LD: begin
                if (r_t < 2'd2) begin
                    n_t = r_t + 2'd1;
                end else begin
                    n_t     = '0;
                    n_i     = '0;
                    n_state = obcc_pkg::S_F_GO;
                end
            end
            obcc_pkg::S_F_GO: n_state = obcc_pkg::S_F_RUN;
            obcc_pkg::S_F_RUN: begin
                if (i_st.mul_done) begin
                    if (r_t == 2'd0) begin
                        n_t     = 2'd1;
                        n_state = obcc_pkg::S_F_GO;
                    end else begin
                        n_state = obcc_pkg::S_F_ST;
                    end
                end
            end
            obcc_pkg::S_F_ST: begin
                n_t = '0;
                if (r_i < 2'd2) begin
                    n_i     = r_i + 2'd1;
                    n_state = obcc_pkg::S_F_GO;
                end else begin
                    n_i = '0;
                    if (r_f < 3'd5) begin
                        n_f     = r_f + 3'd1;
                        n_state = obcc_pkg::S_F_LD;
                    end else begin
                        n_f     = '0;
                        n_k     = '0;
                        n_state = obcc_pkg::S_C_CAM;
                    end
                end
            end
            obcc_pkg::S_C_CAM: begin
                n_i     = '0;
                n_f     = '0;
                n_state = obcc_pkg::S_D_GO;
            end
            obcc_pkg::S_D_GO: n_state = obcc_pkg::S_D_RUN;
            obcc_pkg::S_D_RUN: begin
                if (i_st.mul_done) begin
                    if (r_i < 2'd2) begin
                        n_i     = r_i + 2'd1;
                        n_state = obcc_pkg::S_D_GO;
                    end else begin
                        n_state = obcc_pkg::S_D_EVAL;
                    end
                end
            end
            obcc_pkg::S_D_EVAL: begin
                n_i = '0;
                if (r_f < 3'd5) begin
                    n_f     = r_f + 3'd1;
                    n_state = obcc_pkg::S_D_GO;
                end else begin
                    n_f     = '0;
                    n_state = obcc_pkg::S_D_HIT;
                end
            end
            obcc_pkg::S_D_HIT: begin
                if (r_k < 3'd7) begin
                    n_k     = r_k + 3'd1;
                    n_state = obcc_pkg::S_C_CAM;
                end else begin
                    n_state = obcc_pkg::S_DONE;
                end
            end
            obcc_pkg::S_DONE: begin
                if (i_out_free) n_state = obcc_pkg::S_IDLE;
            end
            default: n_state = obcc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op      = obcc_pkg::OP_NONE;
        o_cmd.msel    = obcc_pkg::M_SQ;
        o_cmd.acc_clr = 1'b0;
        o_cmd.vec     = r_vec;
        o_cmd.k       = r_k;
        o_cmd.i       = r_i;
        o_cmd.f       = r_f;
        o_cmd.t       = r_t;
        o_emit        = 1'b0;
        o_in_ready    = 1'b0;
        unique case (r_state)
            obcc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (w_accept) o_cmd.op = i_func ? obcc_pkg::OP_QLATCH : obcc_pkg::OP_LOAD;
            end
            obcc_pkg::S_N_ABS: o_cmd.op = obcc_pkg::OP_ABS;
            obcc_pkg::S_N_SHIFT: begin
                if (!i_st.zero && i_st.need_shift) o_cmd.op = obcc_pkg::OP_SHIFT;
            end
            obcc_pkg::S_N_SQ_GO: begin
                o_cmd.op      = obcc_pkg::OP_MUL;
                o_cmd.msel    = obcc_pkg::M_SQ;
                o_cmd.acc_clr = (r_t == 2'd0);
            end
            obcc_pkg::S_N_SQRT_GO: o_cmd.op = obcc_pkg::OP_SQRT;
            obcc_pkg::S_N_DIV_GO:  o_cmd.op = obcc_pkg::OP_DIV;
            obcc_pkg::S_N_DIV_ST:  o_cmd.op = obcc_pkg::OP_DIV_ST;
            obcc_pkg::S_P_GO: begin
                o_cmd.op      = obcc_pkg::OP_MUL;
                o_cmd.msel    = obcc_pkg::M_CORNER;
                o_cmd.acc_clr = (r_t == 2'd0);
            end
            obcc_pkg::S_P_ST: o_cmd.op = obcc_pkg::OP_PT_ST;
            obcc_pkg::S_F_LD: o_cmd.op = obcc_pkg::OP_LD_P;
            obcc_pkg::S_F_GO: begin
                o_cmd.op      = obcc_pkg::OP_MUL;
                o_cmd.msel    = obcc_pkg::M_CROSS;
                o_cmd.acc_clr = (r_t == 2'd0);
            end
            obcc_pkg::S_F_ST:  o_cmd.op = obcc_pkg::OP_N_ST;
            obcc_pkg::S_C_CAM: o_cmd.op = obcc_pkg::OP_CAM;
            obcc_pkg::S_D_GO: begin
                o_cmd.op      = obcc_pkg::OP_MUL;
                o_cmd.msel    = obcc_pkg::M_DOT;
                o_cmd.acc_clr = (r_i == 2'd0);
            end
            obcc_pkg::S_D_EVAL: o_cmd.op = obcc_pkg::OP_EVAL;
            obcc_pkg::S_D_HIT:  o_cmd.op = obcc_pkg::OP_HIT;
            obcc_pkg::S_DONE:   o_emit   = i_out_free;
            default: o_cmd.op = obcc_pkg::OP_NONE;
        endcase
    end

endmodule

[sv/obcc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obcc_dp: collision datapath
// Box word store, bit-serial multiply-accumulate, digit-by-digit square root,
// restoring divider and the point, plane and camera corner registers.
// ----------------------------------------------------------------------------
module obcc_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  obcc_pkg::t_cmd    i_cmd,
    input  obcc_pkg::t_item   i_item,
    output obcc_pkg::t_status o_st
);

    localparam int F = obcc_pkg::FRAC_BITS;
    localparam int AW = obcc_pkg::ACC_W;
    localparam logic signed [AW-1:0] HALF    = AW'(1) << (F - 1);
    localparam logic signed [AW-1:0] SAT_MAX = {{(AW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [AW-1:0] SAT_MIN = {{(AW-31){1'b1}}, {31{1'b0}}};
    localparam logic signed [33:0]   C_HALF  = 34'(obcc_pkg::CAM_HALF);
    localparam logic signed [33:0]   C_DROP  = 34'(obcc_pkg::CAM_DROP);

    function automatic logic signed [31:0] round_sat(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] s;
        logic signed [31:0]   res;
        s = (v + HALF) >>> F;
        if (s > SAT_MAX)      res = 32'sh7FFF_FFFF;
        else if (s < SAT_MIN) res = 32'sh8000_0000;
        else                  res = s[31:0];
        return res;
    endfunction

    // Object box corners that span each face plane.
    function automatic logic [2:0] face_pt(input logic [2:0] f, input logic [1:0] t);
        logic [8:0] row;
        unique case (f)
            3'd0:    row = {3'd4, 3'd5, 3'd7};
            3'd1:    row = {3'd0, 3'd4, 3'd6};
            3'd2:    row = {3'd1, 3'd0, 3'd2};
            3'd3:    row = {3'd5, 3'd1, 3'd3};
            3'd4:    row = {3'd6, 3'd7, 3'd3};
            3'd5:    row = {3'd4, 3'd1, 3'd5};
            default: row = '0;
        endcase
        case (t)
            2'd0:    return row[8:6];
            2'd1:    return row[5:3];
            default: return row[2:0];
        endcase
    endfunction

    // Component indices of the two products of one cross product term.
    function automatic logic [3:0] cross_idx(input logic [1:0] n, input logic t);
        logic [1:0] a, b;
        unique case (n)
            2'd0:    begin a = 2'd1; b = 2'd2; end
            2'd1:    begin a = 2'd2; b = 2'd0; end
            default: begin a = 2'd0; b = 2'd1; end
        endcase
        return t ? {b, a} : {a, b};
    endfunction

    logic signed [31:0] r_mat [obcc_pkg::NUM_MAT];
    logic signed [31:0] r_lim [obcc_pkg::NUM_LIM];
    logic signed [31:0] r_cam [3];
    logic signed [31:0] r_vx [2];
    logic signed [31:0] r_vz [2];
    logic signed [31:0] r_nx [2];
    logic signed [31:0] r_nz [2];
    logic        r_isq, r_hit, r_inside;
    logic [31:0] r_ax, r_az;
    logic        r_sgx, r_sgz;

    logic signed [obcc_pkg::MC_W-1:0] r_mc;
    logic [obcc_pkg::B_W-1:0]         r_mp;
    logic [obcc_pkg::MCNT_W-1:0]      r_mcnt;
    logic                             r_mbusy, r_mneg;
    logic signed [AW-1:0]             r_acc;

    logic [63:0] r_sq_n, r_sq_r, r_sq_bit;
    logic [obcc_pkg::SCNT_W-1:0] r_scnt;
    logic        r_sbusy;

    logic [obcc_pkg::DIV_STEPS-1:0] r_dnum;
    logic [31:0]  r_drem;
    logic [F:0]   r_dq;
    logic [obcc_pkg::DCNT_W-1:0] r_dcnt;
    logic         r_dbusy;

    logic signed [31:0]            r_pt    [8][3];
    logic signed [31:0]            r_p     [3][3];
    logic signed [31:0]            r_base  [6][3];
    logic signed [obcc_pkg::A_W-1:0] r_nrm [6][3];
    logic [5:0]                    r_degen;
    logic signed [31:0]            r_c     [3];

    logic signed [obcc_pkg::A_W-1:0] w_opa;
    logic signed [obcc_pkg::B_W-1:0] w_opb;
    logic        w_neg;
    logic [3:0]  w_cidx;
    logic [2:0]  w_lidx;
    logic        w_mdone, w_msub;
    logic signed [obcc_pkg::MC_W-1:0] w_mdelta;
    logic [64:0] w_sq_sum;
    logic [32:0] w_remsh;
    logic signed [AW-1:0] w_trans;
    logic signed [33:0]   w_s0, w_s2, w_s1;
    logic [2:0]  w_fp;
    logic        w_nzero;
    logic [31:0] w_absx, w_absz;
    logic signed [31:0] w_qs;

    assign w_cidx = cross_idx(i_cmd.i, i_cmd.t[0]);
    assign w_lidx = 3'(i_cmd.t) + (i_cmd.k[i_cmd.t] ? 3'd3 : 3'd0);

    always_comb begin
        w_opa = '0;
        w_opb = '0;
        w_neg = 1'b0;
        case (i_cmd.msel)
            obcc_pkg::M_SQ: begin
                w_opa = i_cmd.t[0] ? obcc_pkg::A_W'(r_az) : obcc_pkg::A_W'(r_ax);
                w_opb = i_cmd.t[0] ? {1'b0, r_az} : {1'b0, r_ax};
            end
            obcc_pkg::M_CORNER: begin
                w_opa = obcc_pkg::A_W'(r_mat[{i_cmd.i, i_cmd.t}]);
                w_opb = obcc_pkg::B_W'(r_lim[w_lidx]);
            end
            obcc_pkg::M_CROSS: begin
                w_opa = obcc_pkg::A_W'(obcc_pkg::B_W'(r_p[1][w_cidx[3:2]])
                                       - obcc_pkg::B_W'(r_p[0][w_cidx[3:2]]));
                w_opb = obcc_pkg::B_W'(r_p[2][w_cidx[1:0]])
                        - obcc_pkg::B_W'(r_p[1][w_cidx[1:0]]);
                w_neg = i_cmd.t[0];
            end
            default: begin
                w_opa = r_nrm[i_cmd.f][i_cmd.i];
                w_opb = obcc_pkg::B_W'(r_c[i_cmd.i]) - obcc_pkg::B_W'(r_base[i_cmd.f][i_cmd.i]);
            end
        endcase
    end

    // The top multiplier bit carries negative weight.
    assign w_mdone  = r_mbusy && (r_mcnt == obcc_pkg::MCNT_W'(obcc_pkg::MUL_STEPS - 1));
    assign w_msub   = (r_mcnt == obcc_pkg::MCNT_W'(obcc_pkg::MUL_STEPS - 1)) ^ r_mneg;
    assign w_mdelta = r_mp[0] ? r_mc : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
        end else if (i_cmd.op == obcc_pkg::OP_MUL) begin
            r_mbusy <= 1'b1;
        end else if (w_mdone) begin
            r_mbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == obcc_pkg::OP_MUL) begin
            r_mc   <= obcc_pkg::MC_W'(w_opa);
            r_mp   <= w_opb;
            r_mneg <= w_neg;
            r_mcnt <= '0;
            if (i_cmd.acc_clr) r_acc <= '0;
        end else if (r_mbusy) begin
            r_mc   <= r_mc <<< 1;
            r_mp   <= r_mp >> 1;
            r_mcnt <= r_mcnt + obcc_pkg::MCNT_W'(1);
            r_acc  <= w_msub ? r_acc - AW'(w_mdelta) : r_acc + AW'(w_mdelta);
        end
    end

    // Square root, two radicand bits per step.
    assign w_sq_sum = {1'b0, r_sq_r} + {1'b0, r_sq_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbusy <= 1'b0;
        end else if (i_cmd.op == obcc_pkg::OP_SQRT) begin
            r_sbusy <= 1'b1;
        end else if (r_sbusy && (r_scnt == obcc_pkg::SCNT_W'(obcc_pkg::SQRT_STEPS - 1))) begin
            r_sbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == obcc_pkg::OP_SQRT) begin
            r_sq_n   <= r_acc[63:0];
            r_sq_r   <= '0;
            r_sq_bit <= 64'd1 << 62;
            r_scnt   <= '0;
        end else if (r_sbusy) begin
            if ({1'b0, r_sq_n} >= w_sq_sum) begin
                r_sq_n <= r_sq_n - w_sq_sum[63:0];
                r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
            end else begin
                r_sq_r <= r_sq_r >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
            r_scnt   <= r_scnt + obcc_pkg::SCNT_W'(1);
        end
    end

    // Restoring divider by the square root; the quotient never exceeds one.
    assign w_remsh = {r_drem, r_dnum[obcc_pkg::DIV_STEPS-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
        end else if (i_cmd.op == obcc_pkg::OP_DIV) begin
            r_dbusy <= 1'b1;
        end else if (r_dbusy && (r_dcnt == obcc_pkg::DCNT_W'(obcc_pkg::DIV_STEPS - 1))) begin
            r_dbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == obcc_pkg::OP_DIV) begin
            r_dnum <= {(i_cmd.t[0] ? r_az : r_ax), {F{1'b0}}};
            r_drem <= '0;
            r_dq   <= '0;
            r_dcnt <= '0;
        end else if (r_dbusy) begin
            if (w_remsh >= {1'b0, r_sq_r[31:0]}) begin
                r_drem <= 32'(w_remsh - {1'b0, r_sq_r[31:0]});
                r_dq   <= {r_dq[F-1:0], 1'b1};
            end else begin
                r_drem <= w_remsh[31:0];
                r_dq   <= {r_dq[F-1:0], 1'b0};
            end
            r_dnum <= r_dnum << 1;
            r_dcnt <= r_dcnt + obcc_pkg::DCNT_W'(1);
        end
    end

    // Box word store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < obcc_pkg::NUM_MAT; n++) r_mat[n] <= '0;
            for (int n = 0; n < obcc_pkg::NUM_LIM; n++) r_lim[n] <= '0;
        end else if (i_cmd.op == obcc_pkg::OP_LOAD) begin
            if (i_item.word_index < 5'(obcc_pkg::WORD_LIM)) begin
                r_mat[i_item.word_index[3:0]] <= i_item.word_value;
            end else if (i_item.word_index < 5'(obcc_pkg::NUM_WORDS)) begin
                r_lim[3'(i_item.word_index - 5'(obcc_pkg::WORD_LIM))] <= i_item.word_value;
            end
        end
    end

    assign w_absx = r_vx[i_cmd.vec][31] ? 32'(~r_vx[i_cmd.vec] + 32'd1) : r_vx[i_cmd.vec];
    assign w_absz = r_vz[i_cmd.vec][31] ? 32'(~r_vz[i_cmd.vec] + 32'd1) : r_vz[i_cmd.vec];
    assign w_qs   = (i_cmd.t[0] ? r_sgz : r_sgx) ? -32'(r_dq) : 32'(r_dq);
    assign w_trans = AW'(r_mat[{i_cmd.i, 2'd3}]) <<< F;
    assign w_fp    = face_pt(i_cmd.f, i_cmd.t);
    assign w_nzero = (r_acc == '0);

    // Camera corner: the fixed box offsets are powers of two along x and z.
    assign w_s0 = (i_cmd.k[0] ? 34'(r_nx[0]) : -34'(r_nx[0]))
                + (i_cmd.k[2] ? 34'(r_nx[1]) : -34'(r_nx[1]));
    assign w_s2 = (i_cmd.k[0] ? 34'(r_nz[0]) : -34'(r_nz[0]))
                + (i_cmd.k[2] ? 34'(r_nz[1]) : -34'(r_nz[1]));
    assign w_s1 = 34'(r_cam[1]) + (i_cmd.k[1] ? C_HALF : -C_DROP);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            obcc_pkg::OP_LOAD: begin
                r_isq <= 1'b0;
                r_hit <= 1'b0;
            end
            obcc_pkg::OP_QLATCH: begin
                r_isq    <= 1'b1;
                r_hit    <= 1'b0;
                r_cam[0] <= i_item.cam_x;
                r_cam[1] <= i_item.cam_y;
                r_cam[2] <= i_item.cam_z;
                r_vx[0]  <= i_item.fwd_x;
                r_vz[0]  <= i_item.fwd_z;
                r_vx[1]  <= i_item.right_x;
                r_vz[1]  <= i_item.right_z;
            end
            obcc_pkg::OP_ABS: begin
                r_ax  <= w_absx;
                r_az  <= w_absz;
                r_sgx <= r_vx[i_cmd.vec][31];
                r_sgz <= r_vz[i_cmd.vec][31];
            end
            obcc_pkg::OP_SHIFT: begin
                r_ax <= r_ax << 1;
                r_az <= r_az << 1;
            end
            obcc_pkg::OP_DIV_ST: begin
                if (i_cmd.t[0]) r_nz[i_cmd.vec] <= w_qs;
                else            r_nx[i_cmd.vec] <= w_qs;
            end
            obcc_pkg::OP_PT_ST: r_pt[i_cmd.k][i_cmd.i] <= round_sat(r_acc + w_trans);
            obcc_pkg::OP_LD_P: begin
                for (int n = 0; n < 3; n++) begin
                    r_p[i_cmd.t][n] <= r_pt[w_fp][n];
                    if (i_cmd.t == 2'd0) r_base[i_cmd.f][n] <= r_pt[w_fp][n];
                end
            end
            obcc_pkg::OP_N_ST: begin
                r_nrm[i_cmd.f][i_cmd.i] <= r_acc[obcc_pkg::A_W-1:0];
                r_degen[i_cmd.f] <= (i_cmd.i == 2'd0) ? w_nzero
                                                      : (r_degen[i_cmd.f] & w_nzero);
            end
            obcc_pkg::OP_CAM: begin
                r_c[0]   <= round_sat((AW'(w_s0) <<< (F - 3)) + (AW'(r_cam[0]) <<< F));
                r_c[1]   <= round_sat(AW'(w_s1) <<< F);
                r_c[2]   <= round_sat((AW'(w_s2) <<< (F - 3)) + (AW'(r_cam[2]) <<< F));
                r_inside <= 1'b1;
            end
            obcc_pkg::OP_EVAL: begin
                // A degenerate face, or a corner strictly in front of it, rejects.
                if (r_degen[i_cmd.f] || (!r_acc[AW-1] && !w_nzero)) r_inside <= 1'b0;
            end
            obcc_pkg::OP_HIT: r_hit <= r_hit | r_inside;
            default: ;
        endcase
    end

    assign o_st.zero       = (r_ax == '0) && (r_az == '0);
    assign o_st.need_shift = (r_ax[31:30] == 2'b00) && (r_az[31:30] == 2'b00);
    assign o_st.mul_busy   = r_mbusy;
    assign o_st.mul_done   = w_mdone;
    assign o_st.sqrt_done  = r_sbusy && (r_scnt == obcc_pkg::SCNT_W'(obcc_pkg::SQRT_STEPS - 1));
    assign o_st.div_done   = r_dbusy && (r_dcnt == obcc_pkg::DCNT_W'(obcc_pkg::DIV_STEPS - 1));
    assign o_st.is_query   = r_isq;
    assign o_st.hit        = r_hit;

endmodule

[sv/oriented_box_corner_collision_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oriented_box_corner_collision_unit: camera box against oriented object box
// Stores one object box and transform, and tests the eight corners of the
// camera box against its six face planes on each query transaction.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  s_tuser func, s_tdata box word or query
//  m_*       out        m_tvalid / m_tready  m_tuser is_query, m_tdata collided
//
//  A load passes from acceptance to the done state; its result is registered into
//  the output register once that register is free. A query's length is set by the
//  bit-serial multiplier over 256 products; normalising each of the forward and
//  right vectors adds shifts, a square root and two divides. A zero vector ends
//  the query early. Reset clears the box to zero at once; there is no clearing pass.
//  One transaction is in flight at a time; a held result stalls only the next.
// ----------------------------------------------------------------------------
module oriented_box_corner_collision_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // word_index, word_value, cam_x, cam_y, cam_z, fwd_x, fwd_z, right_x, right_z
    input  logic [obcc_pkg::IN_DATA_W-1:0]    s_tdata,
    // func
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // collided
    output logic [obcc_pkg::OUT_DATA_W-1:0]   m_tdata,
    // is_query
    output logic [0:0]                        m_tuser
);

    obcc_pkg::t_cmd    w_cmd;
    obcc_pkg::t_status w_st;
    obcc_pkg::t_item   w_item;
    logic w_emit, w_out_free;
    logic r_out_valid, r_out_query, r_out_hit;

    assign w_item.word_index = s_tdata[4:0];
    assign w_item.word_value = s_tdata[36:5];
    assign w_item.cam_x      = s_tdata[68:37];
    assign w_item.cam_y      = s_tdata[100:69];
    assign w_item.cam_z      = s_tdata[132:101];
    assign w_item.fwd_x      = s_tdata[164:133];
    assign w_item.fwd_z      = s_tdata[196:165];
    assign w_item.right_x    = s_tdata[228:197];
    assign w_item.right_z    = s_tdata[260:229];

    assign w_out_free = !r_out_valid || m_tready;

    obcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_func     (s_tuser[0]),
        .i_out_free (w_out_free),
        .i_st       (w_st),
        .o_in_ready (s_tready),
        .o_emit     (w_emit),
        .o_cmd      (w_cmd)
    );

    obcc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_item  (w_item),
        .o_st    (w_st)
    );

    // Output register: the result waits here while the next transaction runs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_query <= w_st.is_query;
            r_out_hit   <= w_st.hit;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(obcc_pkg::OUT_DATA_W-1){1'b0}}, r_out_hit};
    assign m_tuser  = r_out_query;

`ifndef SYNTHESIS
    a_load_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_query) |-> !r_out_hit)
        else $error("load result reports a collision");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_out_valid || m_tready))
        else $error("result overwrites an untaken result");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction accepted while one is in flight");

    a_mul_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == obcc_pkg::OP_MUL) |-> !w_st.mul_busy)
        else $error("multiplier started while busy");
`endif

endmodule
